/* hw/rtl/kss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// Types and codes shared by the keyed segment store.
// ----------------------------------------------------------------------------
package kss_pkg;

    typedef enum logic [2:0] {
        OP_HAS   = 3'd0,
        OP_ADD   = 3'd1,
        OP_ACQ   = 3'd2,
        OP_FIND  = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_ZERO_ID   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  source;
        logic [31:0] segment_id;
        logic [31:0] payload_handle;
        logic [31:0] timestamp;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_id;
        logic [31:0] payload_out;
        logic        evicted;
        logic [31:0] evicted_handle;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  source;
        logic [31:0] id;
        logic [31:0] handle;
        logic [31:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
    } t_eng_ctrl;

endpackage

/* hw/rtl/kss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/kss_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_engine
// Walks the used slots of the table RAM, gathers match, free slot, oldest
// slot and next-id results, then forms the write-back and the response.
// ----------------------------------------------------------------------------
module kss_engine import kss_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_eng_ctrl                  i_ctrl,
    input  t_req                       i_req,
    output logic                       o_rd_en,
    output logic [$clog2(ENTRIES)-1:0] o_rd_addr,
    input  t_entry                     i_rd_data,
    output logic                       o_wr_en,
    output logic [$clog2(ENTRIES)-1:0] o_wr_addr,
    output t_entry                     o_wr_data,
    output logic                       o_done,
    output t_rsp                       o_rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int IW = $clog2(ENTRIES + 1);

    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_slot;

    logic          r_hit;
    logic [AW-1:0] r_hit_slot;
    logic [31:0]   r_hit_handle;
    logic          r_free;
    logic [AW-1:0] r_free_slot;
    logic          r_min_vld;
    logic [31:0]   r_min_time;
    logic [AW-1:0] r_min_slot;
    logic [31:0]   r_min_handle;
    logic          r_nx_found;
    logic [31:0]   r_nx_id;

    logic beat_hit, beat_free, beat_min, beat_nx;
    logic wr_req;

    assign o_rd_en   = i_ctrl.scan && (r_idx < r_count);
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_done    = i_ctrl.scan && !(r_idx < r_count) && !r_rd_vld;

    assign beat_hit  = (i_rd_data.id != 32'd0) && (i_rd_data.id == i_req.segment_id)
                       && (i_rd_data.source == i_req.source);
    assign beat_free = (i_rd_data.id == 32'd0);
    assign beat_min  = !r_min_vld || (i_rd_data.stamp < r_min_time);
    assign beat_nx   = (i_rd_data.id != 32'd0) && (i_rd_data.source == i_req.source)
                       && (i_rd_data.id > i_req.segment_id)
                       && (!r_nx_found || (i_rd_data.id < r_nx_id));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= o_rd_en;
            if (i_ctrl.start) begin
                r_idx <= '0;
            end else if (o_rd_en) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= o_rd_addr;
        if (i_ctrl.start) begin
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_min_vld  <= 1'b0;
            r_nx_found <= 1'b0;
        end else if (r_rd_vld) begin
            if (beat_hit && !r_hit) begin
                r_hit        <= 1'b1;
                r_hit_slot   <= r_rd_slot;
                r_hit_handle <= i_rd_data.handle;
            end
            if (beat_free && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= r_rd_slot;
            end
            if (beat_min) begin
                r_min_vld    <= 1'b1;
                r_min_time   <= i_rd_data.stamp;
                r_min_slot   <= r_rd_slot;
                r_min_handle <= i_rd_data.handle;
            end
            if (beat_nx) begin
                r_nx_found <= 1'b1;
                r_nx_id    <= i_rd_data.id;
            end
        end
    end

    always_comb begin
        o_rsp     = '0;
        o_rsp.status = ST_NOT_FOUND;
        wr_req    = 1'b0;
        o_wr_addr = r_hit_slot;
        o_wr_data = '0;
        n_count   = r_count;
        case (i_req.opcode)
            OP_HAS: begin
                o_rsp.status = r_hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_ADD: begin
                if (i_req.segment_id == 32'd0) begin
                    o_rsp.status = ST_ZERO_ID;
                end else if (r_hit) begin
                    o_rsp.status = ST_DUPLICATE;
                end else begin
                    o_rsp.status     = ST_OK;
                    wr_req           = 1'b1;
                    o_wr_data.source = i_req.source;
                    o_wr_data.id     = i_req.segment_id;
                    o_wr_data.handle = i_req.payload_handle;
                    o_wr_data.stamp  = i_req.timestamp;
                    if (r_free) begin
                        o_wr_addr = r_free_slot;
                    end else if (r_count < IW'(ENTRIES)) begin
                        o_wr_addr = r_count[AW-1:0];
                        if (i_ctrl.decide) begin
                            n_count = r_count + IW'(1);
                        end
                    end else begin
                        o_wr_addr            = r_min_slot;
                        o_rsp.evicted        = 1'b1;
                        o_rsp.evicted_handle = r_min_handle;
                    end
                end
            end
            OP_ACQ: begin
                if (r_hit) begin
                    o_rsp.status      = ST_OK;
                    o_rsp.payload_out = r_hit_handle;
                    wr_req            = 1'b1;
                    o_wr_addr         = r_hit_slot;
                    o_wr_data.stamp   = i_req.timestamp;
                end
            end
            OP_FIND: begin
                if (r_nx_found) begin
                    o_rsp.status  = ST_OK;
                    o_rsp.next_id = r_nx_id;
                end
            end
            OP_CLEAR: begin
                o_rsp.status = ST_OK;
                if (i_ctrl.decide) begin
                    n_count = '0;
                end
            end
            default: begin
                o_rsp.status = ST_NOT_FOUND;
            end
        endcase
    end

    assign o_wr_en = i_ctrl.decide && wr_req;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(ENTRIES))
        else $error("slot count beyond table size");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan |-> r_idx <= r_count)
        else $error("scan index ran past used slots");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.decide && o_rsp.evicted |-> r_count == IW'(ENTRIES) && o_rsp.status == ST_OK)
        else $error("eviction with table not full");

    a_next_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.decide && o_rsp.next_id != 32'd0 |-> o_rsp.status == ST_OK)
        else $error("next id reported without ok status");

endmodule

/* hw/rtl/keyed_segment_store_lru_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_segment_store_lru_unit
// Keyed segment table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request reads every used slot of the
// table RAM, one slot per cycle through its single read port, then writes
// back at most one slot before its result is moved into the output register.
// The output register lets the next request be accepted while a result still
// waits. No clearing pass is needed after reset.
module keyed_segment_store_lru_unit import kss_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    localparam int AW = $clog2(ENTRIES);

    t_state    r_state, n_state;
    t_req      r_req;
    t_rsp      r_res;
    t_rsp      r_out_rsp;
    logic      r_out_valid;
    t_eng_ctrl ctrl;
    logic      accept, out_load, scan_done;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    t_entry        rd_data, wr_data;
    t_rsp          eng_rsp;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SCAN;
            S_SCAN:   if (scan_done) n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        ctrl.start  = (r_state == S_IDLE) && i_in_valid;
        ctrl.scan   = (r_state == S_SCAN);
        ctrl.decide = (r_state == S_DECIDE);
        out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_req;
        end
        if (ctrl.decide) begin
            r_res <= eng_rsp;
        end
        if (out_load) begin
            r_out_rsp <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    kss_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_req     (r_req),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_done    (scan_done),
        .o_rsp     (eng_rsp)
    );

    kss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

/* test/tb_keyed_segment_store_lru_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_segment_store_lru_unit
// Self-checking bench for the keyed segment store with LRU replacement.
// ----------------------------------------------------------------------------
// Requests are predicted against a local copy of the slot table at the moment
// of acceptance, and every returned response is compared field by field with
// the oldest prediction. Directed requests cover the edge cases, then a fill
// and eviction sequence, back-pressure, and random traffic over a key pool.
module tb_keyed_segment_store_lru_unit;
    import kss_pkg::*;

    localparam int SLOTS       = 16;
    localparam int KEY_POOL    = 24;
    localparam int STALL_LIMIT = 5000;
    localparam logic [2:0] OP_FIRST_UNUSED = 3'(OP_CLEAR) + 3'd1;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_rsp;

    logic [7:0]  tbl_src    [SLOTS];
    logic [31:0] tbl_id     [SLOTS];
    logic [31:0] tbl_handle [SLOTS];
    logic [31:0] tbl_stamp  [SLOTS];
    int          tbl_count;

    logic [7:0]  pool_src [KEY_POOL];
    logic [31:0] pool_id  [KEY_POOL];

    t_rsp        pending_rsp[$];
    int          err_count   = 0;
    int          idle_cycles = 0;
    int          hold_request = 0;
    int          hold_left    = 0;
    bit          steady       = 0;
    logic [31:0] wall_time    = '0;

    keyed_segment_store_lru_unit #(.ENTRIES(SLOTS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int find_key(input logic [7:0] src, input logic [31:0] id);
        int used;
        used = (tbl_count > SLOTS) ? SLOTS : tbl_count;
        if (id == 0) return SLOTS;
        for (int i = 0; i < used; i++)
            if (tbl_id[i] == id && tbl_src[i] == src) return i;
        return SLOTS;
    endfunction

    function automatic t_rsp predict_store_op(input t_req r);
        t_rsp y;
        int   used;
        int   k;
        bit   found;
        y = '0;
        y.status = ST_NOT_FOUND;
        used = (tbl_count > SLOTS) ? SLOTS : tbl_count;
        found = 0;
        case (r.opcode)
            OP_HAS: begin
                if (find_key(r.source, r.segment_id) < SLOTS) y.status = ST_OK;
            end
            OP_ADD: begin
                if (r.segment_id == 0) begin
                    y.status = ST_ZERO_ID;
                end else if (find_key(r.source, r.segment_id) < SLOTS) begin
                    y.status = ST_DUPLICATE;
                end else begin
                    k = SLOTS;
                    for (int i = 0; i < used; i++) begin
                        if (tbl_id[i] == 0) begin
                            k = i;
                            break;
                        end
                    end
                    if (k == SLOTS) begin
                        if (used < SLOTS) begin
                            k = used;
                            tbl_count = used + 1;
                        end else begin
                            k = 0;
                            for (int i = 1; i < SLOTS; i++)
                                if (tbl_stamp[i] < tbl_stamp[k]) k = i;
                            y.evicted = 1'b1;
                            y.evicted_handle = tbl_handle[k];
                        end
                    end
                    tbl_src[k]    = r.source;
                    tbl_id[k]     = r.segment_id;
                    tbl_handle[k] = r.payload_handle;
                    tbl_stamp[k]  = r.timestamp;
                    y.status = ST_OK;
                end
            end
            OP_ACQ: begin
                k = find_key(r.source, r.segment_id);
                if (k < SLOTS) begin
                    y.payload_out = tbl_handle[k];
                    tbl_stamp[k]  = r.timestamp;
                    tbl_src[k]    = '0;
                    tbl_id[k]     = '0;
                    tbl_handle[k] = '0;
                    y.status = ST_OK;
                end
            end
            OP_FIND: begin
                for (int i = 0; i < used; i++) begin
                    if (tbl_id[i] != 0 && tbl_src[i] == r.source && tbl_id[i] > r.segment_id
                            && (!found || tbl_id[i] < y.next_id)) begin
                        y.next_id = tbl_id[i];
                        found = 1;
                    end
                end
                y.status = found ? ST_OK : ST_NOT_FOUND;
            end
            OP_CLEAR: begin
                tbl_count = 0;
                y.status = ST_OK;
            end
            default: y.status = ST_NOT_FOUND;
        endcase
        return y;
    endfunction

    function automatic t_req mk_req(input logic [2:0] op, input logic [7:0] src,
                                    input logic [31:0] id, input logic [31:0] handle,
                                    input logic [31:0] ts);
        t_req r;
        r.opcode         = op;
        r.source         = src;
        r.segment_id     = id;
        r.payload_handle = handle;
        r.timestamp      = ts;
        return r;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   p;
        int   k;
        p = $urandom_range(0, 99);
        if (p < 85) begin
            k = $urandom_range(0, KEY_POOL - 1);
            r.source     = pool_src[k];
            r.segment_id = pool_id[k];
        end else begin
            r.source     = 8'($urandom_range(0, 255));
            r.segment_id = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
        end
        p = $urandom_range(0, 99);
        if (p < 36)      r.opcode = OP_ADD;
        else if (p < 52) r.opcode = OP_HAS;
        else if (p < 72) r.opcode = OP_ACQ;
        else if (p < 94) r.opcode = OP_FIND;
        else if (p < 97) r.opcode = OP_CLEAR;
        else             r.opcode = OP_FIRST_UNUSED + 3'($urandom_range(0, 2));
        if (r.opcode == OP_FIND) begin
            case ($urandom_range(0, 3))
                0: r.segment_id = '0;
                1: r.segment_id = r.segment_id - 32'd1;
                2: r.segment_id = 32'($urandom);
                default: ;
            endcase
        end
        wall_time = wall_time + 32'($urandom_range(0, 3));
        r.timestamp      = ($urandom_range(0, 9) == 0) ? 32'($urandom) : wall_time;
        r.payload_handle = 32'($urandom);
        return r;
    endfunction

    task automatic init_key_pool();
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_src[k] = (k % 3 == 2) ? 8'hFF : 8'(k % 3);
            case (k)
                0: pool_id[k] = 32'd1;
                1: pool_id[k] = 32'd2;
                2: pool_id[k] = 32'hFFFF_FFFF;
                3: pool_id[k] = 32'h8000_0000;
                default: pool_id[k] = (k % 2 == 0) ? 32'($urandom_range(1, 200))
                                                   : (32'($urandom) | 32'd1);
            endcase
        end
    endtask

    // valid is left high after acceptance; the next call either replaces the
    // payload or drops valid in the same step
    task automatic send_req(input t_req r);
        while (!steady && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pending_rsp.push_back(predict_store_op(r));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_req(mk_req(OP_HAS,   8'd0,   32'd0,          32'd0,          32'd0));
        send_req(mk_req(OP_HAS,   8'hFF,  32'hFFFF_FFFF,  32'd0,          32'd0));
        send_req(mk_req(OP_ADD,   8'd0,   32'd0,          32'h1111_1111,  32'd1));
        send_req(mk_req(OP_ADD,   8'd0,   32'd1,          32'd0,          32'd0));
        send_req(mk_req(OP_ADD,   8'hFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF));
        send_req(mk_req(OP_ADD,   8'hFF,  32'hFFFF_FFFF,  32'h2222_2222,  32'd5));
        send_req(mk_req(OP_ADD,   8'd0,   32'h8000_0000,  32'h1234_5678,  32'd10));
        send_req(mk_req(OP_HAS,   8'd0,   32'd1,          32'd0,          32'd0));
        send_req(mk_req(OP_HAS,   8'hFF,  32'd1,          32'd0,          32'd0));
        send_req(mk_req(OP_FIND,  8'd0,   32'd0,          32'd0,          32'd0));
        send_req(mk_req(OP_FIND,  8'd0,   32'd1,          32'd0,          32'd0));
        send_req(mk_req(OP_FIND,  8'd0,   32'h8000_0000,  32'd0,          32'd0));
        send_req(mk_req(OP_FIND,  8'hFF,  32'hFFFF_FFFE,  32'd0,          32'd0));
        send_req(mk_req(OP_ACQ,   8'hFF,  32'hFFFF_FFFF,  32'd0,          32'd20));
        send_req(mk_req(OP_ACQ,   8'hFF,  32'hFFFF_FFFF,  32'd0,          32'd21));
        send_req(mk_req(OP_ACQ,   8'd0,   32'd0,          32'd0,          32'd22));
        send_req(mk_req(OP_ADD,   8'd5,   32'd7,          32'hA5A5_A5A5,  32'd23));
        for (int i = 0; i < 3; i++)
            send_req(mk_req(OP_FIRST_UNUSED + 3'(i), 8'd5, 32'd7, 32'd0, 32'd0));
        send_req(mk_req(OP_CLEAR, 8'd0,   32'd0,          32'd0,          32'd0));
        send_req(mk_req(OP_HAS,   8'd0,   32'd1,          32'd0,          32'd0));
        send_req(mk_req(OP_ADD,   8'd0,   32'd2,          32'h5A5A_5A5A,  32'd30));
        send_req(mk_req(OP_FIND,  8'd0,   32'd0,          32'd0,          32'd0));
        wait_drained();
    endtask

    // fill every slot with paired time stamps so the oldest pair ties, then
    // force evictions and reuse of a freed slot
    task automatic test_lru_eviction();
        send_req(mk_req(OP_CLEAR, 8'd0, 32'd0, 32'd0, 32'd0));
        for (int i = 0; i < SLOTS; i++)
            send_req(mk_req(OP_ADD, 8'd3, 32'd100 + 32'(i), 32'hC000_0000 + 32'(i),
                            32'd50 - 32'(i / 2)));
        for (int i = 0; i < 3; i++)
            send_req(mk_req(OP_ADD, 8'd3, 32'd200 + 32'(i), 32'hD000_0000 + 32'(i), 32'd60));
        send_req(mk_req(OP_ACQ, 8'd3, 32'd105, 32'd0, 32'd0));
        send_req(mk_req(OP_ADD, 8'd4, 32'd105, 32'hE000_0000, 32'd61));
        send_req(mk_req(OP_ADD, 8'd4, 32'd106, 32'hE000_0001, 32'd62));
        send_req(mk_req(OP_FIND, 8'd3, 32'd0, 32'd0, 32'd0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        steady = 1;
        hold_request = 300;
        for (int i = 0; i < 24; i++)
            send_req(rand_req());
        steady = 0;
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            steady = (i < 300);
            send_req(rand_req());
        end
        steady = 0;
        wait_drained();
    endtask

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h, got %h", $time, fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t unexpected response: expected none, got %p", $time, o_out_rsp);
                err_count++;
            end else begin
                want = pending_rsp.pop_front();
                compare_field("status",         32'(want.status),  32'(o_out_rsp.status));
                compare_field("next_id",        want.next_id,      o_out_rsp.next_id);
                compare_field("payload_out",    want.payload_out,  o_out_rsp.payload_out);
                compare_field("evicted",        32'(want.evicted), 32'(o_out_rsp.evicted));
                compare_field("evicted_handle", want.evicted_handle, o_out_rsp.evicted_handle);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_src[i]    = '0;
            tbl_id[i]     = '0;
            tbl_handle[i] = '0;
            tbl_stamp[i]  = '0;
        end
        tbl_count = 0;
        init_key_pool();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_lru_eviction();
        test_backpressure();
        test_random_traffic(1300);

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
